// ===== rtl/sba_pkg.sv =====
// ---------------------------------------------------------------------------
// Stack block allocator package
// Shared types, codes and constants of the stack block allocator.
// ---------------------------------------------------------------------------
package sba_pkg;

  // Default table depth and the pool size after reset.
  localparam int unsigned MaxEntriesDefault = 1024;
  localparam logic [31:0] PoolReset = 32'd1048576;

  // Request codes.
  typedef enum logic [2:0] {
    MODE_ALLOC       = 3'd0,
    MODE_ALLOC_MOV   = 3'd1,
    MODE_FREE        = 3'd2,
    MODE_FREE_MOV    = 3'd3,
    MODE_REALLOC     = 3'd4,
    MODE_REALLOC_MOV = 3'd5,
    MODE_QUERY       = 3'd6,
    MODE_NONE        = 3'd7
  } mode_e;

  // Status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_NOMEM       = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_NOT_LAST    = 3'd4,
    ST_NOT_FOUND   = 3'd5,
    ST_FIXED_ABOVE = 3'd6,
    ST_GENERIC     = 3'd7
  } status_e;

  // One table entry, as held by a cell.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        movable;
    logic        generic;
  } entry_t;

  // Shift command for a chain of cells.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_PUSH    = 2'd1,
    CELL_POP     = 2'd2,
    CELL_REPLACE = 2'd3
  } cell_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_EXEC    = 3'd1,
    S_SCAN    = 3'd2,
    S_RESTORE = 3'd3,
    S_FINISH  = 3'd4
  } state_e;

  // Round up to a multiple of 64 bytes at 33 bits, minimum 64.
  function automatic logic [32:0] round_size(input logic [31:0] s);
    logic [32:0] t;
    t = {1'b0, s} + 33'd63;
    t[5:0] = 6'd0;
    if (t == 33'd0) begin
      t = 33'd64;
    end
    return t;
  endfunction

endpackage

// ===== rtl/sba_intf.sv =====
// ---------------------------------------------------------------------------
// Stack block allocator channels
// Valid/ready interfaces for requests, responses and the pool size register.
// ---------------------------------------------------------------------------
interface sba_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] address;
  logic [31:0] size;
  logic        generic;
  modport source (output valid, mode, address, size, generic, input ready);
  modport sink (input valid, mode, address, size, generic, output ready);
endinterface

interface sba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [2:0]  status;
  logic [31:0] move_source;
  logic [32:0] move_delta;
  logic [31:0] move_length;
  logic [10:0] block_count;
  logic [31:0] allocated_bytes;
  logic [31:0] free_bytes;
  logic [31:0] high_mark;
  logic [31:0] high_mark_plain;
  modport source (output valid, block_address, status, move_source, move_delta,
                  move_length, block_count, allocated_bytes, free_bytes,
                  high_mark, high_mark_plain, input ready);
  modport sink (input valid, block_address, status, move_source, move_delta,
                move_length, block_count, allocated_bytes, free_bytes,
                high_mark, high_mark_plain, output ready);
endinterface

interface sba_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/sba_cell.sv =====
// ---------------------------------------------------------------------------
// Stack cell
// Holds one table entry and loads from its upper or lower neighbor.
// ---------------------------------------------------------------------------
module sba_cell import sba_pkg::*; (
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  entry_t   up_i,
  input  entry_t   down_i,
  output entry_t   q_o
);

  entry_t entry_q;

  // Push takes the upper neighbor, pop the lower one.
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      CELL_PUSH:    entry_q <= up_i;
      CELL_POP:     entry_q <= down_i;
      CELL_REPLACE: entry_q <= up_i;
      default:      entry_q <= entry_q;
    endcase
  end

  assign q_o = entry_q;

endmodule

// ===== rtl/sba_chain.sv =====
// ---------------------------------------------------------------------------
// Stack chain
// A row of cells forming a shift stack; cell 0 is the top.
// ---------------------------------------------------------------------------
module sba_chain import sba_pkg::*; #(
  parameter int unsigned Depth = MaxEntriesDefault
) (
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  entry_t   head_i,
  output entry_t   top_o
);

  entry_t cell_q [Depth];

  for (genvar j = 0; j < Depth; j++) begin : g_cell
    entry_t   up;
    entry_t   down;
    cell_op_e op;

    // Replace only touches the top cell.
    always_comb begin
      up   = (j == 0) ? head_i : cell_q[(j == 0) ? 0 : j - 1];
      down = (j == Depth - 1) ? '0 : cell_q[(j == Depth - 1) ? j : j + 1];
      op   = ((j == 0) || (op_i != CELL_REPLACE)) ? op_i : CELL_HOLD;
    end

    sba_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .up_i   (up),
      .down_i (down),
      .q_o    (cell_q[j])
    );
  end

  assign top_o = cell_q[0];

endmodule

// ===== rtl/stack_block_allocator.sv =====
// ---------------------------------------------------------------------------
// Stack block allocator
// Pool allocator keeping its blocks as a stack in a chain of cells.
// ---------------------------------------------------------------------------
// One request is handled at a time. Allocate, fixed free, fixed realloc and
// query pass through the execute and finish states to the response register.
// Movable free and realloc walk the stack from the top through a second chain
// of cells, one block per cycle, and shift the blocks back afterward. The
// response is held until taken, and a new request is accepted while it waits.
module stack_block_allocator import sba_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntriesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  sba_req_if.sink   req_i,
  sba_rsp_if.source rsp_o,
  sba_cfg_if.sink   cfg_i
);

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);

  state_e state_q, state_d;

  // Request registers.
  mode_e       mode_q, mode_d;
  logic [31:0] addr_q, addr_d;
  logic [32:0] n_q, n_d;
  logic        gen_q, gen_d;

  // Allocator state.
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] walk_q, walk_d;
  logic [31:0] free_q, free_d;
  logic [31:0] used_q, used_d;
  logic [31:0] genb_q, genb_d;
  logic [31:0] peak_q, peak_d;
  logic [31:0] peakp_q, peakp_d;

  // Walk accumulators.
  logic [31:0] len_q, len_d;
  logic [31:0] src_q, src_d;
  logic        fixed_q, fixed_d;
  logic [31:0] adj_q, adj_d;

  // Pending result.
  logic [31:0] res_addr_q, res_addr_d;
  status_e     res_st_q, res_st_d;
  logic [31:0] res_src_q, res_src_d;
  logic [32:0] res_delta_q, res_delta_d;
  logic [31:0] res_len_q, res_len_d;

  // Response register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q, out_addr_d;
  status_e     out_st_q, out_st_d;
  logic [31:0] out_src_q, out_src_d;
  logic [32:0] out_delta_q, out_delta_d;
  logic [31:0] out_len_q, out_len_d;
  logic [10:0] out_cnt_q, out_cnt_d;
  logic [31:0] out_used_q, out_used_d;
  logic [31:0] out_free_q, out_free_d;
  logic [31:0] out_peak_q, out_peak_d;
  logic [31:0] out_peakp_q, out_peakp_d;

  // Chains.
  cell_op_e main_op, hold_op;
  entry_t   main_head, hold_head, main_top, hold_top;

  // Shared decisions.
  logic        req_acc, cfg_acc, slot_free, hit, table_full, walk_end;
  logic [32:0] room_alloc, room_resize;
  logic [31:0] old_size, used_grow, used_resize;

  sba_chain #(.Depth(MAX_ENTRIES)) u_main (
    .clk_i (clk_i), .op_i (main_op), .head_i (main_head), .top_o (main_top)
  );

  sba_chain #(.Depth(MAX_ENTRIES)) u_hold (
    .clk_i (clk_i), .op_i (hold_op), .head_i (hold_head), .top_o (hold_top)
  );

  // Handshakes.
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;

  // Common comparisons on the top cell and the counters.
  always_comb begin
    old_size    = main_top.size;
    hit         = (main_top.offset == addr_q);
    table_full  = (count_q >= CntW'(MAX_ENTRIES));
    walk_end    = (walk_q == count_q);
    room_alloc  = {1'b0, free_q};
    room_resize = {1'b0, free_q} + {1'b0, old_size};
    used_grow   = used_q + n_q[31:0];
    used_resize = used_q - old_size + n_q[31:0];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if ((mode_q == MODE_FREE_MOV || mode_q == MODE_REALLOC_MOV) &&
            count_q != '0) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN: begin
        if (walk_end || hit) begin
          state_d = S_RESTORE;
        end
      end
      S_RESTORE: begin
        if (walk_q == '0) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and chain control.
  always_comb begin
    mode_d      = mode_q;
    addr_d      = addr_q;
    n_d         = n_q;
    gen_d       = gen_q;
    count_d     = count_q;
    walk_d      = walk_q;
    free_d      = free_q;
    used_d      = used_q;
    genb_d      = genb_q;
    peak_d      = peak_q;
    peakp_d     = peakp_q;
    len_d       = len_q;
    src_d       = src_q;
    fixed_d     = fixed_q;
    adj_d       = adj_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    res_src_d   = res_src_q;
    res_delta_d = res_delta_q;
    res_len_d   = res_len_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    out_src_d   = out_src_q;
    out_delta_d = out_delta_q;
    out_len_d   = out_len_q;
    out_cnt_d   = out_cnt_q;
    out_used_d  = out_used_q;
    out_free_d  = out_free_q;
    out_peak_d  = out_peak_q;
    out_peakp_d = out_peakp_q;
    main_op     = CELL_HOLD;
    hold_op     = CELL_HOLD;
    main_head   = main_top;
    hold_head   = main_top;

    unique case (state_q)
      // Latch the request and clear the pending result.
      S_IDLE: begin
        if (req_acc) begin
          mode_d      = mode_e'(req_i.mode);
          addr_d      = req_i.address;
          n_d         = round_size(req_i.size);
          gen_d       = req_i.generic;
          res_addr_d  = '0;
          res_st_d    = ST_OK;
          res_src_d   = '0;
          res_delta_d = '0;
          res_len_d   = '0;
          walk_d      = '0;
          len_d       = '0;
          src_d       = '0;
          fixed_d     = 1'b0;
          adj_d       = '0;
        end
      end

      // Requests that touch only the top of the stack; movable ones only check for an empty stack here.
      S_EXEC: begin
        unique case (mode_q)
          MODE_ALLOC, MODE_ALLOC_MOV: begin
            if (table_full) begin
              res_st_d = ST_FULL;
            end else if (n_q > room_alloc) begin
              res_st_d = ST_NOMEM;
            end else begin
              main_op   = CELL_PUSH;
              main_head = '{offset: used_q, size: n_q[31:0],
                            movable: (mode_q == MODE_ALLOC_MOV), generic: gen_q};
              count_d    = count_q + CntW'(1);
              free_d     = free_q - n_q[31:0];
              used_d     = used_grow;
              genb_d     = gen_q ? genb_q + n_q[31:0] : genb_q;
              res_addr_d = used_q;
              if (used_grow - genb_d > peakp_q) begin
                peakp_d = used_grow - genb_d;
              end
              if (used_grow > peak_q) begin
                peak_d = used_grow;
              end
            end
          end
          MODE_NONE: begin
            res_st_d = ST_OK;
          end
          default: begin
            if (count_q == '0) begin
              res_st_d = ST_EMPTY;
            end else if (mode_q == MODE_QUERY) begin
              res_addr_d = main_top.offset;
            end else if (mode_q == MODE_FREE || mode_q == MODE_REALLOC) begin
              if (!hit) begin
                res_st_d = ST_NOT_LAST;
              end else if (mode_q == MODE_FREE) begin
                main_op    = CELL_POP;
                count_d    = count_q - CntW'(1);
                used_d     = used_q - old_size;
                genb_d     = main_top.generic ? genb_q - old_size : genb_q;
                free_d     = free_q + old_size;
                res_addr_d = addr_q;
              end else if (n_q > room_resize) begin
                res_st_d = ST_NOMEM;
              end else begin
                main_op        = CELL_REPLACE;
                main_head.size = n_q[31:0];
                free_d         = room_resize[31:0] - n_q[31:0];
                used_d         = used_resize;
                genb_d         = main_top.generic ? genb_q - old_size + n_q[31:0]
                                                  : genb_q;
                res_addr_d     = addr_q;
                if (used_resize > peak_q) begin
                  peak_d = used_resize;
                end
              end
            end
          end
        endcase
      end

      // Walk down from the top, parking passed blocks in the holding chain.
      S_SCAN: begin
        if (walk_end) begin
          res_st_d = ST_NOT_FOUND;
        end else if (hit) begin
          if (fixed_q) begin
            res_st_d = ST_FIXED_ABOVE;
          end else if (mode_q == MODE_FREE_MOV) begin
            main_op     = CELL_POP;
            count_d     = count_q - CntW'(1);
            used_d      = used_q - old_size;
            genb_d      = main_top.generic ? genb_q - old_size : genb_q;
            free_d      = free_q + old_size;
            adj_d       = 32'd0 - old_size;
            res_addr_d  = addr_q;
            if (walk_q != '0) begin
              res_src_d   = src_q;
              res_delta_d = 33'd0 - {1'b0, old_size};
              res_len_d   = len_q;
            end
          end else if (main_top.generic) begin
            res_st_d = ST_GENERIC;
          end else if (n_q > room_resize) begin
            res_st_d = ST_NOMEM;
          end else begin
            main_op        = CELL_REPLACE;
            main_head.size = n_q[31:0];
            free_d         = room_resize[31:0] - n_q[31:0];
            used_d         = used_resize;
            adj_d          = n_q[31:0] - old_size;
            res_addr_d     = addr_q;
            if (used_resize > peak_q) begin
              peak_d = used_resize;
            end
            if (walk_q != '0) begin
              res_src_d   = src_q;
              res_delta_d = n_q - {1'b0, old_size};
              res_len_d   = len_q;
            end
          end
        end else begin
          main_op   = CELL_POP;
          hold_op   = CELL_PUSH;
          hold_head = main_top;
          len_d     = len_q + old_size;
          src_d     = main_top.offset;
          fixed_d   = fixed_q || !main_top.movable;
          walk_d    = walk_q + CntW'(1);
        end
      end

      // Shift the parked blocks back, moved by the size change.
      S_RESTORE: begin
        if (walk_q != '0) begin
          main_op          = CELL_PUSH;
          main_head        = hold_top;
          main_head.offset = hold_top.offset + adj_q;
          hold_op          = CELL_POP;
          walk_d           = walk_q - CntW'(1);
        end
      end

      // Hand the result to the response register.
      S_FINISH: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_st_d    = res_st_q;
          out_src_d   = res_src_q;
          out_delta_d = res_delta_q;
          out_len_d   = res_len_q;
          out_cnt_d   = 11'(count_q);
          out_used_d  = used_q;
          out_free_d  = free_q;
          out_peak_d  = peak_q;
          out_peakp_d = peakp_q;
        end
      end

      default: begin
        main_op = CELL_HOLD;
      end
    endcase

    // Pool size writes recompute the free byte count.
    if (cfg_acc) begin
      free_d = (cfg_i.data > used_q) ? cfg_i.data - used_q : 32'd0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      free_q      <= PoolReset;
      used_q      <= '0;
      genb_q      <= '0;
      peak_q      <= '0;
      peakp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      free_q      <= free_d;
      used_q      <= used_d;
      genb_q      <= genb_d;
      peak_q      <= peak_d;
      peakp_q     <= peakp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    addr_q      <= addr_d;
    n_q         <= n_d;
    gen_q       <= gen_d;
    len_q       <= len_d;
    src_q       <= src_d;
    fixed_q     <= fixed_d;
    adj_q       <= adj_d;
    res_addr_q  <= res_addr_d;
    res_st_q    <= res_st_d;
    res_src_q   <= res_src_d;
    res_delta_q <= res_delta_d;
    res_len_q   <= res_len_d;
    out_addr_q  <= out_addr_d;
    out_st_q    <= out_st_d;
    out_src_q   <= out_src_d;
    out_delta_q <= out_delta_d;
    out_len_q   <= out_len_d;
    out_cnt_q   <= out_cnt_d;
    out_used_q  <= out_used_d;
    out_free_q  <= out_free_d;
    out_peak_q  <= out_peak_d;
    out_peakp_q <= out_peakp_d;
  end

  // Response port.
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.block_address   = out_addr_q;
  assign rsp_o.status          = out_st_q;
  assign rsp_o.move_source     = out_src_q;
  assign rsp_o.move_delta      = out_delta_q;
  assign rsp_o.move_length     = out_len_q;
  assign rsp_o.block_count     = out_cnt_q;
  assign rsp_o.allocated_bytes = out_used_q;
  assign rsp_o.free_bytes      = out_free_q;
  assign rsp_o.high_mark       = out_peak_q;
  assign rsp_o.high_mark_plain = out_peakp_q;

endmodule

// ===== rtl/sba_checker.sv =====
// ---------------------------------------------------------------------------
// Stack block allocator checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
module sba_assertions import sba_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [31:0] block_address,
  input logic [31:0] move_length,
  input logic [10:0] block_count
);

  // After a request is accepted, the block drops ready while it handles it.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  // A pending response stays until taken.
  a_rsp_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(status))
    else $error("response dropped before transaction");

  // A failed request reports no block and no move.
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status != ST_OK) |-> (block_address == '0 && move_length == '0))
    else $error("failed request reports a block or move");

  // An empty stack is reported only with no blocks.
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status == ST_EMPTY) |-> (block_count == '0))
    else $error("empty status with blocks allocated");

endmodule

bind stack_block_allocator sba_assertions u_sba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (req_i.valid),
  .in_ready      (req_i.ready),
  .out_valid     (rsp_o.valid),
  .out_ready     (rsp_o.ready),
  .status        (rsp_o.status),
  .block_address (rsp_o.block_address),
  .move_length   (rsp_o.move_length),
  .block_count   (rsp_o.block_count)
);
